FILE: rtl/core/hsv_saturation_value_modulator_assert.svh
// assertion macros used by the checker file
`ifndef HSV_SATURATION_VALUE_MODULATOR_ASSERT_SVH
`define HSV_SATURATION_VALUE_MODULATOR_ASSERT_SVH

// property that holds at every clock edge outside reset
`define HSVM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked in the cycle after the antecedent
`define HSVM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/core/hsvm_pkg.sv
// ----------------------------------------------------------------------------
// hsvm_pkg
// types, constants and a restoring divide step for the modulator
// ----------------------------------------------------------------------------
package hsvm_pkg;

	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIV_STAGES = 16;

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_MIN    = 3'd1;
	localparam logic [2:0] REG_MAX    = 3'd2;

	typedef struct packed {
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
		logic [7:0]  alpha_in;
		logic signed [31:0] secondary_value;
		logic        secondary_invalid;
		logic        last_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       last_out;
	} pix_out_t;

	// pixel side data carried alongside the fraction divider
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
		logic       bypass;
		logic       black;
	} side_t;

	// pipeline control flowing between the modules
	typedef struct packed {
		logic valid;
		logic advance;
	} pipe_ctl_t;

	// one restoring step of floor(num*65536/den) on 65-bit remainders
	function automatic logic [64:0] div_step(input logic [64:0] rem, input logic [63:0] den,
		output logic bit_o);
		logic [65:0] sh;
		sh = {rem, 1'b0};
		if (sh >= {2'b00, den}) begin
			bit_o = 1'b1;
			div_step = 65'(sh - {2'b00, den});
		end else begin
			bit_o = 1'b0;
			div_step = sh[64:0];
		end
	endfunction

endpackage

FILE: rtl/core/hsv_saturation_value_modulator.sv
// ----------------------------------------------------------------------------
// hsv_saturation_value_modulator
// rgba pixel modulator: saturation and brightness follow a secondary sample
// ----------------------------------------------------------------------------
// Accepts one pixel per cycle while the output is not stalled and returns one result
// per pixel, in order; the result reaches the output register through 38 register
// stages: one input stage, a 16-stage divider for the sample fraction, one hsv
// analysis stage, a 16-stage pair of dividers for saturation and hue, three
// multiply stages and the output register. A stall at the output freezes the whole
// pipeline; a bubble moves up while the output register is empty.
module hsv_saturation_value_modulator
	import hsvm_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pix_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output pix_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        enable_q;
	logic [31:0] min_q, max_q;
	logic [2:0]  ridx;
	assign ridx   = {1'b0, paddr[3:2]};
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			min_q    <= '0;
			max_q    <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_MIN:    min_q    <= pwdata;
				REG_MAX:    max_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_ENABLE: prdata = {31'd0, enable_q};
			REG_MIN:    prdata = min_q;
			REG_MAX:    prdata = max_q;
			default:    prdata = '0;
		endcase
	end

	pipe_ctl_t ctl;
	assign ctl.advance = !(out_valid && out_stall);
	assign ctl.valid   = in_valid;
	assign in_stall    = !ctl.advance;

	// sign extend from the sample width
	localparam int W = SAMPLE_WIDTH;
	logic signed [W:0] val_x, min_x, max_x;
	logic [W:0] diff, range;
	side_t side;
	always_comb begin
		val_x = (W+1)'($signed(in_data.secondary_value[W > 32 ? 31 : W-1 : 0]));
		min_x = (W+1)'($signed(min_q[W > 32 ? 31 : W-1 : 0]));
		max_x = (W+1)'($signed(max_q[W > 32 ? 31 : W-1 : 0]));
		diff  = val_x - min_x;
		range = max_x - min_x;
		side.r = in_data.red_in;
		side.g = in_data.green_in;
		side.b = in_data.blue_in;
		side.a = in_data.alpha_in;
		side.last = in_data.last_pixel;
		side.bypass = !enable_q;
		side.black = in_data.secondary_invalid || !(min_x < max_x) || (val_x < min_x)
			|| (val_x >= max_x);
	end

	// input register
	logic            vld_s1;
	side_t           side_s1;
	logic [W:0]      diff_s1, range_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (ctl.advance) vld_s1 <= ctl.valid;
	end
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			side_s1  <= side;
			diff_s1  <= side.black ? '0 : diff;
			range_s1 <= side.black ? (W+1)'(1) : range;
		end
	end

	logic        vld_f;
	side_t       side_f;
	logic [16:0] v_f;
	hsvm_frac_div #(.SAMPLE_WIDTH(W)) u_div (
		.clk(clk), .arst_n(arst_n), .advance(ctl.advance),
		.valid_in(vld_s1), .side_in(side_s1), .diff_in(diff_s1), .range_in(range_s1),
		.valid_out(vld_f), .side_out(side_f), .v_out(v_f)
	);

	hsvm_hsv_rgb u_hsv (
		.clk(clk), .arst_n(arst_n), .advance(ctl.advance),
		.valid_in(vld_f), .side_in(side_f), .v_in(v_f),
		.valid_out(out_valid), .pix_out(out_data)
	);

endmodule

FILE: rtl/core/hsvm_frac_div.sv
// ----------------------------------------------------------------------------
// hsvm_frac_div
// pipelined radix-2 divider giving v = 1 - (value-min)/(max-min) in Q1.16
// ----------------------------------------------------------------------------
module hsvm_frac_div
	import hsvm_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    valid_in,
	input  side_t                   side_in,
	input  logic [SAMPLE_WIDTH:0]   diff_in,
	input  logic [SAMPLE_WIDTH:0]   range_in,
	output logic                    valid_out,
	output side_t                   side_out,
	output logic [16:0]             v_out
);

	localparam int W = SAMPLE_WIDTH + 1;

	logic         vld_s1 [DIV_STAGES];
	side_t        side_s1 [DIV_STAGES];
	logic [W:0]   rem_s1 [DIV_STAGES];
	logic [W-1:0] den_s1 [DIV_STAGES];
	logic [15:0]  q_s1 [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [W:0]   rem_prev;
		logic [W-1:0] den_prev;
		logic [15:0]  q_prev;
		logic [W+1:0] sh;
		logic         bt;
		logic [W:0]   rem_nx;
		if (k == 0) begin : g_first
			assign rem_prev = {1'b0, diff_in};
			assign den_prev = range_in;
			assign q_prev   = '0;
		end else begin : g_rest
			assign rem_prev = rem_s1[k-1];
			assign den_prev = den_s1[k-1];
			assign q_prev   = q_s1[k-1];
		end
		always_comb begin
			sh = {rem_prev, 1'b0};
			bt = (sh >= {2'b00, den_prev});
			rem_nx = bt ? (W+1)'(sh - {2'b00, den_prev}) : sh[W:0];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k] <= 1'b0;
			end else if (advance) begin
				vld_s1[k] <= (k == 0) ? valid_in : vld_s1[k-1 < 0 ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				side_s1[k] <= (k == 0) ? side_in : side_s1[k-1 < 0 ? 0 : k-1];
				rem_s1[k]  <= rem_nx;
				den_s1[k]  <= den_prev;
				q_s1[k]    <= {q_prev[14:0], bt};
			end
		end
	end

	assign valid_out = vld_s1[DIV_STAGES-1];
	assign side_out  = side_s1[DIV_STAGES-1];
	assign v_out     = 17'h10000 - {1'b0, q_s1[DIV_STAGES-1]};

endmodule

FILE: rtl/core/hsvm_hsv_rgb.sv
// ----------------------------------------------------------------------------
// hsvm_hsv_rgb
// rgb to hsv analysis, saturation and hue dividers, and hsv back to rgb
// ----------------------------------------------------------------------------
module hsvm_hsv_rgb
	import hsvm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       valid_in,
	input  side_t      side_in,
	input  logic [16:0] v_in,
	output logic       valid_out,
	output pix_out_t   pix_out
);

	// ---- analysis stage: max, min, d, numerator split
	logic [7:0] mx, mn, d;
	logic [2:0]  base;
	logic [7:0]  nrem;
	always_comb begin
		mx = side_in.r;
		if (side_in.g > mx) mx = side_in.g;
		if (side_in.b > mx) mx = side_in.b;
		mn = side_in.r;
		if (side_in.g < mn) mn = side_in.g;
		if (side_in.b < mn) mn = side_in.b;
		d = mx - mn;
		// sextant and remainder come straight from which channel is max
		if (side_in.r == mx) begin
			if (side_in.g >= side_in.b) begin
				base = 3'd0;
				nrem = side_in.g - side_in.b;
			end else begin
				base = 3'd5;
				nrem = d - (side_in.b - side_in.g);
			end
		end else if (side_in.g == mx) begin
			if (side_in.b >= side_in.r) begin
				base = 3'd2;
				nrem = side_in.b - side_in.r;
			end else begin
				base = 3'd1;
				nrem = d - (side_in.r - side_in.b);
			end
		end else begin
			if (side_in.r >= side_in.g) begin
				base = 3'd4;
				nrem = side_in.r - side_in.g;
			end else begin
				base = 3'd3;
				nrem = d - (side_in.g - side_in.r);
			end
		end
		// a full remainder belongs to the start of the next sextant
		if (nrem == d && d != 8'd0) begin
			base = base + 3'd1;
			nrem = '0;
		end
	end

	logic        vld_a;
	side_t       side_a;
	logic [16:0] v_a;
	logic [7:0]  mx_a, d_a, nrem_a;
	logic [2:0]  sext_a;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_a <= 1'b0;
		else if (advance) vld_a <= valid_in;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			side_a <= side_in;
			v_a    <= v_in;
			mx_a   <= mx;
			d_a    <= d;
			nrem_a <= nrem;
			sext_a <= base;
		end
	end

	// ---- two 16-step dividers in lockstep: s = d/mx, f = nrem/d
	localparam int NS = 16;
	logic        vld_d [NS];
	side_t       side_d [NS];
	logic [16:0] v_d [NS];
	logic [2:0]  sx_d [NS];
	logic [7:0]  d_d [NS];
	logic [7:0]  mx_d [NS];
	logic [8:0]  rs_d [NS];
	logic [8:0]  rf_d [NS];
	logic [15:0] qs_d [NS];
	logic [15:0] qf_d [NS];

	for (genvar k = 0; k < NS; k++) begin : g_div
		logic        vp;
		side_t       sp;
		logic [16:0] vvp;
		logic [2:0]  xp;
		logic [7:0]  dp, mp;
		logic [8:0]  rsp, rfp, rsn, rfn;
		logic [15:0] qsp, qfp;
		logic [9:0]  shs, shf;
		logic        bs, bf;
		if (k == 0) begin : g_first
			assign vp = vld_a; assign sp = side_a; assign vvp = v_a; assign xp = sext_a;
			assign dp = d_a; assign mp = mx_a;
			assign rsp = {1'b0, d_a}; assign rfp = {1'b0, nrem_a};
			assign qsp = '0; assign qfp = '0;
		end else begin : g_rest
			assign vp = vld_d[k-1]; assign sp = side_d[k-1]; assign vvp = v_d[k-1];
			assign xp = sx_d[k-1]; assign dp = d_d[k-1]; assign mp = mx_d[k-1];
			assign rsp = rs_d[k-1]; assign rfp = rf_d[k-1];
			assign qsp = qs_d[k-1]; assign qfp = qf_d[k-1];
		end
		always_comb begin
			shs = {rsp, 1'b0};
			bs  = (shs >= {2'b00, mp});
			rsn = bs ? 9'(shs - {2'b00, mp}) : shs[8:0];
			shf = {rfp, 1'b0};
			bf  = (shf >= {2'b00, dp});
			rfn = bf ? 9'(shf - {2'b00, dp}) : shf[8:0];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[k] <= 1'b0;
			else if (advance) vld_d[k] <= vp;
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				side_d[k] <= sp; v_d[k] <= vvp; sx_d[k] <= xp;
				d_d[k] <= dp; mx_d[k] <= mp;
				rs_d[k] <= rsn; rf_d[k] <= rfn;
				qs_d[k] <= {qsp[14:0], bs};
				qf_d[k] <= {qfp[14:0], bf};
			end
		end
	end

	// ---- stage m1: s' = s*v
	logic        vld_m1;
	side_t       side_m1;
	logic [16:0] v_m1, sp_m1, f_m1;
	logic [2:0]  sx_m1;
	logic        grey_m1;
	logic [16:0] s_full;
	logic [33:0] spx;
	always_comb begin
		s_full = (d_d[NS-1] == mx_d[NS-1]) ? 17'h10000 : {1'b0, qs_d[NS-1]};
		spx = s_full * v_d[NS-1];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_m1 <= 1'b0;
		else if (advance) vld_m1 <= vld_d[NS-1];
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			side_m1 <= side_d[NS-1];
			v_m1    <= v_d[NS-1];
			sp_m1   <= spx[32:16];
			f_m1    <= {1'b0, qf_d[NS-1]};
			sx_m1   <= sx_d[NS-1];
			grey_m1 <= (d_d[NS-1] == 8'd0);
		end
	end

	// ---- stage m2: s'*f and s'*(1-f)
	logic        vld_m2;
	side_t       side_m2;
	logic [16:0] v_m2, sp_m2, sf_m2, sg_m2;
	logic [2:0]  sx_m2;
	logic        grey_m2;
	logic [33:0] sfx, sgx;
	always_comb begin
		sfx = sp_m1 * f_m1;
		sgx = sp_m1 * (17'h10000 - f_m1);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_m2 <= 1'b0;
		else if (advance) vld_m2 <= vld_m1;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			side_m2 <= side_m1; v_m2 <= v_m1; sp_m2 <= sp_m1;
			sf_m2 <= sfx[32:16]; sg_m2 <= sgx[32:16];
			sx_m2 <= sx_m1; grey_m2 <= grey_m1;
		end
	end

	// ---- stage m3: p, q, t
	logic        vld_m3;
	side_t       side_m3;
	logic [16:0] v_m3, p_m3, q_m3, t_m3;
	logic [2:0]  sx_m3;
	logic        grey_m3;
	logic [33:0] px, qx, tx;
	always_comb begin
		px = v_m2 * (17'h10000 - sp_m2);
		qx = v_m2 * (17'h10000 - sf_m2);
		tx = v_m2 * (17'h10000 - sg_m2);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_m3 <= 1'b0;
		else if (advance) vld_m3 <= vld_m2;
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			side_m3 <= side_m2; v_m3 <= v_m2;
			p_m3 <= px[32:16]; q_m3 <= qx[32:16]; t_m3 <= tx[32:16];
			sx_m3 <= sx_m2; grey_m3 <= grey_m2;
		end
	end

	// ---- output stage: sextant select, scale by 255, special cases
	function automatic logic [7:0] to8(input logic [16:0] c);
		logic [24:0] m;
		m = {c, 8'd0} - {8'd0, c};
		to8 = m[23:16];
	endfunction

	logic [16:0] c0, c1, c2;
	pix_out_t    res;
	always_comb begin
		case (sx_m3)
			3'd0: begin c0 = v_m3; c1 = t_m3; c2 = p_m3; end
			3'd1: begin c0 = q_m3; c1 = v_m3; c2 = p_m3; end
			3'd2: begin c0 = p_m3; c1 = v_m3; c2 = t_m3; end
			3'd3: begin c0 = p_m3; c1 = q_m3; c2 = v_m3; end
			3'd4: begin c0 = t_m3; c1 = p_m3; c2 = v_m3; end
			default: begin c0 = v_m3; c1 = p_m3; c2 = q_m3; end
		endcase
		if (grey_m3) begin
			c0 = v_m3; c1 = v_m3; c2 = v_m3;
		end
		res.alpha_out = side_m3.a;
		res.last_out  = side_m3.last;
		if (side_m3.bypass) begin
			res.red_out = side_m3.r; res.green_out = side_m3.g; res.blue_out = side_m3.b;
		end else if (side_m3.black) begin
			res.red_out = '0; res.green_out = '0; res.blue_out = '0;
		end else begin
			res.red_out = to8(c0); res.green_out = to8(c1); res.blue_out = to8(c2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_out <= 1'b0;
		else if (advance) valid_out <= vld_m3;
	end
	always_ff @(posedge clk) begin
		if (advance) pix_out <= res;
	end

endmodule

FILE: rtl/core/hsvm_checker.sv
// ----------------------------------------------------------------------------
// hsvm_checker
// port-level checks on the modulator handshakes
// ----------------------------------------------------------------------------
`include "hsv_saturation_value_modulator_assert.svh"
module hsvm_checker
	import hsvm_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input pix_out_t out_data,
	input logic     pready
);

	`HSVM_ASSERT(a_pready, clk, arst_n, pready, "pready low")
	`HSVM_ASSERT(a_stall_only_back, clk, arst_n, in_stall == (out_valid && out_stall), "in_stall mismatch")
	`HSVM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind hsv_saturation_value_modulator hsvm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data), .pready(pready)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// hsv saturation/value modulator testbench
// drives pixels through the valid/stall ports, predicts every result with an
// independent fixed-point hsv model and compares results in order, with
// random idling on both sides and a long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import hsvm_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	pix_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	pix_out_t    out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	hsv_saturation_value_modulator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	localparam int LATENCY = 39;

	// predictor copy of the registers
	logic               mod_en;
	logic signed [31:0] lim_min;
	logic signed [31:0] lim_max;

	pix_in_t  pending_pixels[$];
	pix_out_t expected_pixels[$];
	int       error_count;
	bit       quiet_in;
	bit       quiet_out;
	int       holdoff_left;
	bit       holdoff_req;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// floor(num * 65536 / den), num < den
	function automatic logic [15:0] frac16(logic [63:0] num, logic [63:0] den);
		logic [64:0] rem;
		logic [15:0] q;
		rem = {1'b0, num};
		q = '0;
		for (int k = 0; k < 16; k++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [7:0] chan8(logic [63:0] c);
		logic [63:0] x;
		x = (c * 255) >> 16;
		return x[7:0];
	endfunction

	function automatic pix_out_t predict_pixel(pix_in_t px);
		pix_out_t o;
		logic [63:0] r, g, b, mx, mn, d, s, sp, n, f, p, q, t, v, sext_v, range, diff;
		logic [63:0] c[3];
		logic [63:0] sextant;
		r = px.red_in; g = px.green_in; b = px.blue_in;
		o.alpha_out = px.alpha_in;
		o.last_out = px.last_pixel;
		if (!mod_en) begin
			o.red_out = px.red_in; o.green_out = px.green_in; o.blue_out = px.blue_in;
			return o;
		end
		o.red_out = 0; o.green_out = 0; o.blue_out = 0;
		if (px.secondary_invalid || lim_min >= lim_max || px.secondary_value < lim_min)
			return o;
		range = 64'(signed'(lim_max)) - 64'(signed'(lim_min));
		sext_v = 64'(signed'(px.secondary_value));
		diff = sext_v - 64'(signed'(lim_min));
		if (diff >= range)
			return o;
		v = 65536 - frac16(diff, range);
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		if (d == 0) begin
			o.red_out = chan8(v); o.green_out = chan8(v); o.blue_out = chan8(v);
			return o;
		end
		s = (d == mx) ? 64'd65536 : 64'(frac16(d, mx));
		sp = (s * v) >> 16;
		if (r == mx) n = (g >= b) ? (g - b) : (6 * d - (b - g));
		else if (g == mx) n = 2 * d + b - r;
		else n = 4 * d + r - g;
		sextant = n / d;
		f = frac16(n % d, d);
		p = (v * (65536 - sp)) >> 16;
		q = (v * (65536 - ((sp * f) >> 16))) >> 16;
		t = (v * (65536 - ((sp * (65536 - f)) >> 16))) >> 16;
		case (sextant)
			0: begin c[0] = v; c[1] = t; c[2] = p; end
			1: begin c[0] = q; c[1] = v; c[2] = p; end
			2: begin c[0] = p; c[1] = v; c[2] = t; end
			3: begin c[0] = p; c[1] = q; c[2] = v; end
			4: begin c[0] = t; c[1] = p; c[2] = v; end
			default: begin c[0] = v; c[1] = p; c[2] = q; end
		endcase
		o.red_out = chan8(c[0]); o.green_out = chan8(c[1]); o.blue_out = chan8(c[2]);
		return o;
	endfunction

	// driver: feeds pending pixels, predicts each on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall)
				expected_pixels.push_back(predict_pixel(in_data));
			if (!in_valid || !in_stall) begin
				if (pending_pixels.size() > 0 && (quiet_in || $urandom_range(99) >= 21)) begin
					in_valid <= 1'b1;
					in_data <= pending_pixels.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long output hold-off, counted in cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
		end else if (holdoff_req && holdoff_left == 0) begin
			holdoff_left <= 200;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// monitor and output stall generator
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					error_count++;
				end else begin
					pix_out_t e;
					e = expected_pixels.pop_front();
					if (e.red_out !== out_data.red_out)
						$display("%0t: red expected %0d actual %0d", $time, e.red_out,
							out_data.red_out);
					if (e.green_out !== out_data.green_out)
						$display("%0t: green expected %0d actual %0d", $time, e.green_out,
							out_data.green_out);
					if (e.blue_out !== out_data.blue_out)
						$display("%0t: blue expected %0d actual %0d", $time, e.blue_out,
							out_data.blue_out);
					if (e.alpha_out !== out_data.alpha_out)
						$display("%0t: alpha expected %0d actual %0d", $time, e.alpha_out,
							out_data.alpha_out);
					if (e.last_out !== out_data.last_out)
						$display("%0t: last expected %0d actual %0d", $time, e.last_out,
							out_data.last_out);
					if (e !== out_data)
						error_count++;
				end
			end
			if (holdoff_req || holdoff_left > 0)
				out_stall <= 1'b1;
			else
				out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 21);
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx[1:0], 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_ENABLE: mod_en = val[0];
			REG_MIN: lim_min = val;
			REG_MAX: lim_max = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic pix_in_t rand_pixel(logic signed [31:0] lo, logic signed [31:0] hi);
		pix_in_t px;
		logic [63:0] span;
		px.red_in = $urandom; px.green_in = $urandom; px.blue_in = $urandom;
		px.alpha_in = $urandom;
		px.secondary_invalid = ($urandom_range(19) == 0);
		px.last_pixel = ($urandom_range(15) == 0);
		span = 64'(signed'(hi)) - 64'(signed'(lo));
		case ($urandom_range(9))
			0: px.secondary_value = $urandom;
			1: px.secondary_value = lo;
			2: px.secondary_value = hi;
			3: px.secondary_value = lo - 1;
			4: if ($urandom_range(1)) begin
				px.red_in = px.green_in; px.blue_in = px.green_in;
				px.secondary_value = lo;
			end else px.secondary_value = hi + 1;
			default: px.secondary_value = 32'(64'(signed'(lo)) +
				(({$urandom, $urandom}) % (span + 1)));
		endcase
		return px;
	endfunction

	task automatic run_phase(input logic en, input logic signed [31:0] lo,
		input logic signed [31:0] hi, input int count);
		reg_write(REG_ENABLE, {31'd0, en});
		reg_write(REG_MIN, lo);
		reg_write(REG_MAX, hi);
		for (int k = 0; k < count; k++)
			pending_pixels.push_back(rand_pixel(lo, hi));
		wait_drained();
	endtask

	initial begin
		pix_in_t px;
		logic [7:0] cols[7][3];
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mod_en = 1'b0; lim_min = '0; lim_max = '0;
		error_count = 0;
		quiet_in = 0; quiet_out = 0; holdoff_req = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: disabled pass-through of extreme pixels
		px = '0; pending_pixels.push_back(px);
		px = '1; pending_pixels.push_back(px);
		wait_drained();
		// directed: one pixel per sextant plus grey and black, full brightness and mid
		reg_write(REG_ENABLE, 32'd1);
		reg_write(REG_MIN, 32'd0);
		reg_write(REG_MAX, 32'd1000);
		cols = '{'{255, 40, 0}, '{200, 255, 10}, '{0, 255, 90}, '{5, 100, 255},
			'{120, 0, 255}, '{255, 0, 60}, '{128, 128, 128}};
		for (int k = 0; k < 7; k++) begin
			px = '0;
			px.red_in = cols[k][0]; px.green_in = cols[k][1]; px.blue_in = cols[k][2];
			px.alpha_in = 8'(k * 37);
			px.secondary_value = (k % 2) ? 32'sd500 : 32'sd0;
			pending_pixels.push_back(px);
		end
		px = '0; px.alpha_in = 8'hff; pending_pixels.push_back(px);
		px = '0; px.red_in = 9; px.secondary_invalid = 1; pending_pixels.push_back(px);
		px.secondary_invalid = 0; px.secondary_value = -1; pending_pixels.push_back(px);
		px.secondary_value = 1000; pending_pixels.push_back(px);
		px.secondary_value = 999; px.last_pixel = 1; pending_pixels.push_back(px);
		wait_drained();
		// directed: empty range
		reg_write(REG_MAX, 32'd0);
		px = '1; px.secondary_invalid = 0; px.secondary_value = 0;
		pending_pixels.push_back(px);
		wait_drained();

		// random phases, extremes of the limits included
		quiet_in = 1; quiet_out = 1;
		run_phase(1, 32'sd0, 32'sd65535, 150);
		quiet_in = 0; quiet_out = 0;
		run_phase(1, 32'sh80000000, 32'sh7fffffff, 250);
		run_phase(1, -32'sd100, 32'sd100, 250);
		run_phase(1, 32'sd7, 32'sd8, 100);
		run_phase(0, 32'sd0, 32'sd10, 150);
		run_phase(1, 32'sd50, -32'sd50, 100);
		// long output hold-off while pixels keep coming
		reg_write(REG_ENABLE, 32'd1);
		for (int k = 0; k < 150; k++)
			pending_pixels.push_back(rand_pixel(32'sd0, 32'sd100000));
		holdoff_req = 1;
		wait (holdoff_left != 0);
		holdoff_req = 0;
		wait_drained();
		run_phase(1, 32'sh7ffffff0, 32'sh7fffffff, 150);
		run_phase(1, -32'sd1000000, 32'sd3000000, 150);

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
